@@ src/sorted_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_macros.svh
// Assertion macros used by the sorted priority queue module.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Checked outside reset only.
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int ACTION_BITS = 2;
	localparam int STATUS_BITS = 2;
	localparam int INS_CNT_BITS = 32;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_INSERT = 2'd0,
		ACT_POP    = 2'd1,
		ACT_REMOVE = 2'd2
	} spq_action_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} spq_status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic do_insert;
		logic do_pop;
		logic do_remove;
	} spq_cell_ctl_t;

endpackage

@@ src/spq_req_if.sv @@
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: action, entry time and entry id.
// ----------------------------------------------------------------------------
interface spq_req_if
	import spq_pkg::*;
#(
	parameter int TIME_BITS = 48,
	parameter int ID_BITS   = 16
);
	logic                   valid;
	logic                   ready;
	logic [ACTION_BITS-1:0] action;
	logic [TIME_BITS-1:0]   entry_time;
	logic [ID_BITS-1:0]     entry_id;

	modport source (output valid, output action, output entry_time, output entry_id,
		input ready);
	modport sink (input valid, input action, input entry_time, input entry_id,
		output ready);
endinterface

@@ src/spq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: status, returned entry and counters.
// ----------------------------------------------------------------------------
interface spq_rsp_if
	import spq_pkg::*;
#(
	parameter int TIME_BITS = 48,
	parameter int ID_BITS   = 16,
	parameter int CNT_BITS  = 7
);
	logic                    valid;
	logic                    ready;
	logic [STATUS_BITS-1:0]  status;
	logic [TIME_BITS-1:0]    out_time;
	logic [ID_BITS-1:0]      out_id;
	logic [CNT_BITS-1:0]     occupancy;
	logic [CNT_BITS-1:0]     peak_occupancy;
	logic [INS_CNT_BITS-1:0] inserts_total;

	modport source (output valid, output status, output out_time, output out_id,
		output occupancy, output peak_occupancy, output inserts_total, input ready);
	modport sink (input valid, input status, input out_time, input out_id,
		input occupancy, input peak_occupancy, input inserts_total, output ready);
endinterface

@@ src/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a key and id, compares against the
// request and takes data from the request or its left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int TIME_BITS = 48,
	parameter int ID_BITS   = 16
) (
	input  logic                 clk,
	input  spq_cell_ctl_t        ctl,
	input  logic                 valid,
	input  logic [TIME_BITS-1:0] new_time,
	input  logic [ID_BITS-1:0]   new_id,
	input  logic                 prev_le,
	input  logic [TIME_BITS-1:0] prev_time,
	input  logic [ID_BITS-1:0]   prev_id,
	input  logic [TIME_BITS-1:0] next_time,
	input  logic [ID_BITS-1:0]   next_id,
	input  logic                 found_in,
	output logic                 le,
	output logic                 found_out,
	output logic                 hit,
	output logic [TIME_BITS-1:0] key,
	output logic [ID_BITS-1:0]   id
);
	logic [TIME_BITS-1:0] key_q;
	logic [ID_BITS-1:0]   id_q;
	logic                 match;

	assign le        = valid && (key_q <= new_time);
	assign match     = valid && (id_q == new_id);
	assign found_out = found_in | match;
	assign hit       = match & ~found_in;
	assign key       = key_q;
	assign id        = id_q;

	always_ff @(posedge clk) begin
		if (ctl.do_insert && !le) begin
			if (prev_le) begin
				key_q <= new_time;
				id_q  <= new_id;
			end else begin
				key_q <= prev_time;
				id_q  <= prev_id;
			end
		end else if (ctl.do_pop || (ctl.do_remove && found_out)) begin
			key_q <= next_time;
			id_q  <= next_id;
		end
	end
endmodule

@@ src/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Time-ordered queue of (time, id) entries kept in a row of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: action (insert, pop smallest, remove by id), the
//   entry time and the entry id. rsp returns one item per request: status,
//   the popped or removed entry (zero otherwise), occupancy after the
//   operation, peak occupancy and a wrapping 32-bit insert count.
//   Every cell compares its key and id against the request at once and
//   all cells shift together, so one request is taken per cycle while rsp is
//   not stalled; its response is valid in the output register on the next cycle.
//   Equal times leave in insertion order. Remove takes the matching entry
//   nearest the head. Insert into a full queue reports full and changes
//   nothing.
//   While rsp is stalled the output register holds; req.ready is high only
//   while that register is empty or is read in the same cycle.
//   Reset clears occupancy, peak, insert count and output valid; slot contents
//   are not reset and are only ever read below the occupancy.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY  = 64,
	parameter int TIME_BITS = 48,
	parameter int ID_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	spq_cell_ctl_t        ctl;
	logic                 fire;
	logic                 full;
	logic                 empty;
	logic [CNT_BITS-1:0]  fill_q;
	logic [CNT_BITS-1:0]  peak_q;
	logic [CNT_BITS-1:0]  fill_nxt;
	logic [INS_CNT_BITS-1:0] ins_q;

	logic [CAPACITY-1:0]  valid;
	logic [CAPACITY-1:0]  le;
	logic [CAPACITY-1:0]  found;
	logic [CAPACITY-1:0]  hit;
	logic [TIME_BITS-1:0] key  [CAPACITY];
	logic [ID_BITS-1:0]   id   [CAPACITY];

	logic [TIME_BITS-1:0] rm_time;
	logic [ID_BITS-1:0]   rm_id;

	logic                 out_valid_q;
	spq_status_t          status_q;
	logic [TIME_BITS-1:0] out_time_q;
	logic [ID_BITS-1:0]   out_id_q;

	spq_status_t          status_d;
	logic [TIME_BITS-1:0] out_time_d;
	logic [ID_BITS-1:0]   out_id_d;

	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = (fill_q == CNT_BITS'(CAPACITY));
	assign empty     = (fill_q == '0);

	assign ctl.do_insert = fire && (req.action == ACT_INSERT) && !full;
	assign ctl.do_pop    = fire && (req.action == ACT_POP) && !empty;
	assign ctl.do_remove = fire && (req.action == ACT_REMOVE);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign valid[i] = (CNT_BITS'(i) < fill_q);

		spq_cell #(
			.TIME_BITS(TIME_BITS),
			.ID_BITS  (ID_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.valid    (valid[i]),
			.new_time (req.entry_time),
			.new_id   (req.entry_id),
			.prev_le  ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i-1]),
			.prev_time(key[(i == 0) ? 0 : i-1]),
			.prev_id  (id[(i == 0) ? 0 : i-1]),
			.next_time(key[(i == CAPACITY-1) ? i : i+1]),
			.next_id  (id[(i == CAPACITY-1) ? i : i+1]),
			.found_in ((i == 0) ? 1'b0 : found[(i == 0) ? 0 : i-1]),
			.le       (le[i]),
			.found_out(found[i]),
			.hit      (hit[i]),
			.key      (key[i]),
			.id       (id[i])
		);
	end

	// one-hot select of the removed entry
	always_comb begin
		rm_time = '0;
		rm_id   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rm_time = rm_time | (key[i] & {TIME_BITS{hit[i]}});
			rm_id   = rm_id | (id[i] & {ID_BITS{hit[i]}});
		end
	end

	always_comb begin
		status_d   = ST_OK;
		out_time_d = '0;
		out_id_d   = '0;
		fill_nxt   = fill_q;
		unique case (req.action)
			ACT_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					fill_nxt = fill_q + 1'b1;
				end
			end
			ACT_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					out_time_d = key[0];
					out_id_d   = id[0];
					fill_nxt   = fill_q - 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (!found[CAPACITY-1]) begin
					status_d = ST_NOTFOUND;
				end else begin
					out_time_d = rm_time;
					out_id_d   = rm_id;
					fill_nxt   = fill_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			peak_q      <= '0;
			ins_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				fill_q      <= fill_nxt;
				if (fill_nxt > peak_q) begin
					peak_q <= fill_nxt;
				end
				if (ctl.do_insert) begin
					ins_q <= ins_q + 1'b1;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q   <= status_d;
			out_time_q <= out_time_d;
			out_id_q   <= out_id_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.out_time       = out_time_q;
	assign rsp.out_id         = out_id_q;
	assign rsp.occupancy      = fill_q;
	assign rsp.peak_occupancy = peak_q;
	assign rsp.inserts_total  = ins_q;

	`SPQ_ASSERT_ALWAYS(a_fill_bound, fill_q <= CNT_BITS'(CAPACITY), "occupancy above capacity")
	`SPQ_ASSERT(a_peak_ge_fill, peak_q >= fill_q, "peak below occupancy")
	`SPQ_ASSERT(a_pop_dec, ctl.do_pop |=> fill_q == $past(fill_q) - 1'b1, "pop did not shrink")
	`SPQ_ASSERT(a_ins_cnt, ctl.do_insert |=> ins_q == $past(ins_q) + 1'b1, "insert not counted")
	`SPQ_ASSERT(a_one_hit, $onehot0(hit), "more than one remove match selected")
	`SPQ_ASSERT(a_skid, out_valid_q && !rsp.ready |-> !req.ready, "accepted while output stalled")
endmodule
